// File: design/cpu8eu_pkg.sv
// ----------------------------------------------------------------------------
// cpu8eu_pkg
// Shared types and constants of the 8-bit CPU execute unit.
// ----------------------------------------------------------------------------
package cpu8eu_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int BANK_DEPTH  = STACK_DEPTH / 2;
  localparam int BANK_AW     = STACK_AW - 1;

  localparam logic [7:0]  SP_RESET = 8'hFF;
  localparam logic [7:0]  SP_EMPTY = 8'hFF;
  localparam logic [7:0]  SP_FULL  = 8'h00;

  typedef enum logic [4:0] {
    FN_NOP      = 5'd0,
    FN_LOAD     = 5'd1,
    FN_STORE    = 5'd2,
    FN_AND      = 5'd3,
    FN_OR       = 5'd4,
    FN_XOR      = 5'd5,
    FN_ADC      = 5'd6,
    FN_COMPARE  = 5'd7,
    FN_INCMEM   = 5'd8,
    FN_DECMEM   = 5'd9,
    FN_INCREG   = 5'd10,
    FN_DECREG   = 5'd11,
    FN_BIT      = 5'd12,
    FN_ASL      = 5'd13,
    FN_LSR      = 5'd14,
    FN_PUSH     = 5'd15,
    FN_PULL     = 5'd16,
    FN_JMP      = 5'd17,
    FN_JSR      = 5'd18,
    FN_RTS      = 5'd19,
    FN_BRANCH   = 5'd20,
    FN_CLRFLAG  = 5'd21,
    FN_SETFLAG  = 5'd22,
    FN_TRANSFER = 5'd23
  } func_t;

  typedef enum logic [2:0] {
    RS_A  = 3'd0,
    RS_X  = 3'd1,
    RS_Y  = 3'd2,
    RS_SP = 3'd3,
    RS_P  = 3'd4
  } reg_sel_t;

  typedef enum logic [1:0] {
    TRAP_NONE      = 2'd0,
    TRAP_SEGV      = 2'd1,
    TRAP_OVERFLOW  = 2'd2,
    TRAP_UNDERFLOW = 2'd3
  } trap_t;

  typedef struct packed {
    logic [4:0]  func;
    logic [2:0]  src_reg;
    logic [2:0]  dst_reg;
    logic [2:0]  flag_bit;
    logic        br_on_set;
    logic [7:0]  operand;
    logic [15:0] eff_address;
    logic        acc_mode;
    logic        read_ok;
    logic [15:0] next_pc;
  } item_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic [15:0] new_pc;
    logic        mem_write;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    trap_t       trap;
  } result_t;

  // Two stack writes per word at most, at sp and at sp - 1.
  typedef struct packed {
    logic       w0_en;
    logic [7:0] w0_addr;
    logic [7:0] w0_data;
    logic       w1_en;
    logic [7:0] w1_addr;
    logic [7:0] w1_data;
  } stk_wr_t;

endpackage

// File: design/cpu8_execute_unit.sv
// ----------------------------------------------------------------------------
// cpu8_execute_unit
// Execute stage of an 8-bit CPU with its register file and stack page.
//
// Each word on the s_axis channel is one decoded instruction with its operand
// byte, effective address and next PC already resolved. Each word on the
// m_axis channel reports the registers after that instruction, the new PC,
// an optional data memory write and a trap code; exactly one result word is
// produced per instruction, in order.
// An instruction is captured in an input register, executed there once the
// output register is free, and its result is registered in the output
// register that drives m_axis. One instruction is accepted every cycle while
// the result words are taken. The
// stack page is split into even and odd banks, each with one read and one
// write port, so a subroutine call or return touches both bytes in a cycle;
// the stack bytes are read when an instruction is captured.
// Reset sets A, X, Y and P to zero, SP to 0xFF and marks every stack entry as
// zero. While m_axis_tready is low the result word is held,
// one more instruction may wait in the input register, and s_axis_tready
// then drops until the result is taken.
// ----------------------------------------------------------------------------
module cpu8_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[4:0], src_reg[7:5], dst_reg[10:8], flag_bit[13:11],
  // br_on_set[14], operand[22:15], eff_address[38:23], acc_mode[39],
  // read_ok[40], next_pc[56:41], zero[63:57].
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // acc_out[7:0], x_out[15:8], y_out[23:16], sp_out[31:24],
  // status_out[39:32], new_pc[55:40], mem_write[56], write_address[72:57],
  // write_data[80:73], trap[82:81], zero[87:83].
  output logic [87:0] m_axis_tdata
);

  localparam int BAW = cpu8eu_pkg::BANK_AW;
  localparam int SAW = cpu8eu_pkg::STACK_AW;

  logic                  in_valid;
  cpu8eu_pkg::item_t     in_item;
  cpu8eu_pkg::regs_t     regs;
  cpu8eu_pkg::regs_t     regs_next;
  cpu8eu_pkg::result_t   res;
  cpu8eu_pkg::stk_wr_t   stk_wr;
  cpu8eu_pkg::regs_t     out_regs;
  cpu8eu_pkg::result_t   out_res;
  logic                  fire;
  logic                  accept;
  logic [7:0]            rd_base;
  logic [7:0]            rd_a0;
  logic [7:0]            rd_a1;
  logic                  rd_par;
  logic [7:0]            even_data;
  logic [7:0]            odd_data;
  logic [7:0]            stk_byte0;
  logic [7:0]            stk_byte1;
  logic                  even_we;
  logic [BAW-1:0]        even_waddr;
  logic [7:0]            even_wdata;
  logic                  odd_we;
  logic [BAW-1:0]        odd_waddr;
  logic [7:0]            odd_wdata;
  logic [BAW-1:0]        even_raddr;
  logic [BAW-1:0]        odd_raddr;

  assign fire          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item.func        <= s_axis_tdata[4:0];
      in_item.src_reg     <= s_axis_tdata[7:5];
      in_item.dst_reg     <= s_axis_tdata[10:8];
      in_item.flag_bit    <= s_axis_tdata[13:11];
      in_item.br_on_set   <= s_axis_tdata[14];
      in_item.operand     <= s_axis_tdata[22:15];
      in_item.eff_address <= s_axis_tdata[38:23];
      in_item.acc_mode    <= s_axis_tdata[39];
      in_item.read_ok     <= s_axis_tdata[40];
      in_item.next_pc     <= s_axis_tdata[56:41];
    end
  end

  cpu8eu_exec u_exec (
    .item      (in_item),
    .regs      (regs),
    .stk_byte0 (stk_byte0),
    .stk_byte1 (stk_byte1),
    .regs_next (regs_next),
    .res       (res),
    .stk_wr    (stk_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.a  <= 8'h00;
      regs.x  <= 8'h00;
      regs.y  <= 8'h00;
      regs.sp <= cpu8eu_pkg::SP_RESET;
      regs.p  <= 8'h00;
    end else if (fire) begin
      regs <= regs_next;
    end
  end

  // The next word reads the two bytes above the stack pointer it will see.
  assign rd_base = fire ? regs_next.sp : regs.sp;
  assign rd_a0   = rd_base + 8'd1;
  assign rd_a1   = rd_base + 8'd2;

  assign even_raddr = rd_a0[0] ? rd_a1[SAW-1:1] : rd_a0[SAW-1:1];
  assign odd_raddr  = rd_a0[0] ? rd_a0[SAW-1:1] : rd_a1[SAW-1:1];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_par <= rd_a0[0];
    end
  end

  assign stk_byte0 = rd_par ? odd_data : even_data;
  assign stk_byte1 = rd_par ? even_data : odd_data;

  always_comb begin
    even_we    = 1'b0;
    even_waddr = '0;
    even_wdata = '0;
    odd_we     = 1'b0;
    odd_waddr  = '0;
    odd_wdata  = '0;
    if (fire && stk_wr.w0_en) begin
      if (stk_wr.w0_addr[0]) begin
        odd_we    = 1'b1;
        odd_waddr = stk_wr.w0_addr[SAW-1:1];
        odd_wdata = stk_wr.w0_data;
      end else begin
        even_we    = 1'b1;
        even_waddr = stk_wr.w0_addr[SAW-1:1];
        even_wdata = stk_wr.w0_data;
      end
    end
    if (fire && stk_wr.w1_en) begin
      if (stk_wr.w1_addr[0]) begin
        odd_we    = 1'b1;
        odd_waddr = stk_wr.w1_addr[SAW-1:1];
        odd_wdata = stk_wr.w1_data;
      end else begin
        even_we    = 1'b1;
        even_waddr = stk_wr.w1_addr[SAW-1:1];
        even_wdata = stk_wr.w1_data;
      end
    end
  end

  cpu8eu_stack_bank u_even_bank (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (even_we),
    .wr_addr (even_waddr),
    .wr_data (even_wdata),
    .rd_en   (accept),
    .rd_addr (even_raddr),
    .rd_data (even_data)
  );

  cpu8eu_stack_bank u_odd_bank (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (odd_we),
    .wr_addr (odd_waddr),
    .wr_data (odd_wdata),
    .rd_en   (accept),
    .rd_addr (odd_raddr),
    .rd_data (odd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_regs <= regs_next;
      out_res  <= res;
    end
  end

  assign m_axis_tdata = {5'b00000, out_res.trap, out_res.write_data, out_res.write_address,
                         out_res.mem_write, out_res.new_pc, out_regs.p, out_regs.sp,
                         out_regs.y, out_regs.x, out_regs.a};

endmodule

// File: design/cpu8eu_stack_bank.sv
// ----------------------------------------------------------------------------
// cpu8eu_stack_bank
// One half of the stack page, holding either the even or the odd entries.
// Entries read as zero until written; reads are registered and see a write
// at the same edge.
// ----------------------------------------------------------------------------
module cpu8eu_stack_bank (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [cpu8eu_pkg::BANK_AW-1:0]  wr_addr,
  input  logic [7:0]                      wr_data,
  input  logic                            rd_en,
  input  logic [cpu8eu_pkg::BANK_AW-1:0]  rd_addr,
  output logic [7:0]                      rd_data
);

  logic [7:0]                          mem [cpu8eu_pkg::BANK_DEPTH];
  logic [cpu8eu_pkg::BANK_DEPTH-1:0]   valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// File: design/cpu8eu_exec.sv
// ----------------------------------------------------------------------------
// cpu8eu_exec
// Combinational execute logic: one decoded word against the register file
// and the two stack bytes above the stack pointer.
// ----------------------------------------------------------------------------
module cpu8eu_exec (
  input  cpu8eu_pkg::item_t    item,
  input  cpu8eu_pkg::regs_t    regs,
  input  logic [7:0]           stk_byte0,
  input  logic [7:0]           stk_byte1,
  output cpu8eu_pkg::regs_t    regs_next,
  output cpu8eu_pkg::result_t  res,
  output cpu8eu_pkg::stk_wr_t  stk_wr
);

  function automatic logic [7:0] set_nz(logic [7:0] p, logic [7:0] v);
    logic [7:0] q;
    q    = p;
    q[7] = v[7];
    q[1] = (v == 8'h00);
    return q;
  endfunction

  function automatic logic [7:0] read_reg(cpu8eu_pkg::regs_t r, logic [2:0] sel);
    logic [7:0] v;
    unique case (cpu8eu_pkg::reg_sel_t'(sel))
      cpu8eu_pkg::RS_A:  v = r.a;
      cpu8eu_pkg::RS_X:  v = r.x;
      cpu8eu_pkg::RS_Y:  v = r.y;
      cpu8eu_pkg::RS_SP: v = r.sp;
      cpu8eu_pkg::RS_P:  v = r.p;
      default:           v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic cpu8eu_pkg::regs_t write_reg(cpu8eu_pkg::regs_t r, logic [2:0] sel,
                                                  logic [7:0] v);
    cpu8eu_pkg::regs_t q;
    q = r;
    unique case (cpu8eu_pkg::reg_sel_t'(sel))
      cpu8eu_pkg::RS_A: begin
        q.a = v;
        q.p = set_nz(q.p, v);
      end
      cpu8eu_pkg::RS_X: begin
        q.x = v;
        q.p = set_nz(q.p, v);
      end
      cpu8eu_pkg::RS_Y: begin
        q.y = v;
        q.p = set_nz(q.p, v);
      end
      cpu8eu_pkg::RS_SP: q.sp = v;
      cpu8eu_pkg::RS_P:  q.p  = v;
      default:           q    = r;
    endcase
    return q;
  endfunction

  always_comb begin
    cpu8eu_pkg::regs_t rn;
    logic              reads;
    logic [8:0]        sum;
    logic [7:0]        r;
    logic [7:0]        v;
    logic [7:0]        lo;
    logic [7:0]        hi;
    logic [15:0]       ret;
    logic [7:0]        m;

    rn         = regs;
    m          = item.operand;
    res        = '0;
    res.new_pc = item.next_pc;
    res.trap   = cpu8eu_pkg::TRAP_NONE;
    stk_wr     = '0;
    sum        = '0;
    r          = '0;
    v          = '0;
    lo         = '0;
    hi         = '0;
    ret        = '0;

    unique case (cpu8eu_pkg::func_t'(item.func))
      cpu8eu_pkg::FN_LOAD, cpu8eu_pkg::FN_AND, cpu8eu_pkg::FN_OR, cpu8eu_pkg::FN_XOR,
      cpu8eu_pkg::FN_ADC, cpu8eu_pkg::FN_COMPARE, cpu8eu_pkg::FN_INCMEM,
      cpu8eu_pkg::FN_DECMEM, cpu8eu_pkg::FN_BIT: reads = 1'b1;
      cpu8eu_pkg::FN_ASL, cpu8eu_pkg::FN_LSR:    reads = !item.acc_mode;
      default:                                   reads = 1'b0;
    endcase

    if (reads && !item.read_ok) begin
      res.trap = cpu8eu_pkg::TRAP_SEGV;
    end else begin
      unique case (cpu8eu_pkg::func_t'(item.func))
        cpu8eu_pkg::FN_LOAD: rn = write_reg(regs, item.dst_reg, m);
        cpu8eu_pkg::FN_STORE: begin
          res.mem_write     = 1'b1;
          res.write_address = item.eff_address;
          res.write_data    = read_reg(regs, item.src_reg);
        end
        cpu8eu_pkg::FN_AND: begin
          rn.a = regs.a & m;
          rn.p = set_nz(regs.p, rn.a);
        end
        cpu8eu_pkg::FN_OR: begin
          rn.a = regs.a | m;
          rn.p = set_nz(regs.p, rn.a);
        end
        cpu8eu_pkg::FN_XOR: begin
          rn.a = regs.a ^ m;
          rn.p = set_nz(regs.p, rn.a);
        end
        cpu8eu_pkg::FN_ADC: begin
          sum     = {1'b0, regs.a} + {1'b0, m} + {8'h00, regs.p[0]};
          r       = sum[7:0];
          rn.p[0] = sum[8];
          rn.p[6] = (regs.a[7] ^ r[7]) & (m[7] ^ r[7]);
          rn.a    = r;
          rn.p    = set_nz(rn.p, r);
        end
        cpu8eu_pkg::FN_COMPARE: begin
          v       = read_reg(regs, item.src_reg);
          rn.p    = set_nz(regs.p, v - m);
          rn.p[0] = (v >= m);
        end
        cpu8eu_pkg::FN_INCMEM, cpu8eu_pkg::FN_DECMEM: begin
          r = (cpu8eu_pkg::func_t'(item.func) == cpu8eu_pkg::FN_INCMEM) ? m + 8'd1 : m - 8'd1;
          rn.p              = set_nz(regs.p, r);
          res.mem_write     = 1'b1;
          res.write_address = item.eff_address;
          res.write_data    = r;
        end
        cpu8eu_pkg::FN_INCREG:
          rn = write_reg(regs, item.dst_reg, read_reg(regs, item.dst_reg) + 8'd1);
        cpu8eu_pkg::FN_DECREG:
          rn = write_reg(regs, item.dst_reg, read_reg(regs, item.dst_reg) - 8'd1);
        cpu8eu_pkg::FN_BIT: begin
          rn.p[7:6] = m[7:6];
          rn.p[1]   = ((regs.a & m) == 8'h00);
        end
        cpu8eu_pkg::FN_ASL, cpu8eu_pkg::FN_LSR: begin
          v = item.acc_mode ? regs.a : m;
          if (cpu8eu_pkg::func_t'(item.func) == cpu8eu_pkg::FN_ASL) begin
            rn.p[0] = v[7];
            r       = {v[6:0], 1'b0};
          end else begin
            rn.p[0] = v[0];
            r       = {1'b0, v[7:1]};
          end
          rn.p = set_nz(rn.p, r);
          if (item.acc_mode) begin
            rn.a = r;
          end else begin
            res.mem_write     = 1'b1;
            res.write_address = item.eff_address;
            res.write_data    = r;
          end
        end
        cpu8eu_pkg::FN_PUSH: begin
          if (regs.sp == cpu8eu_pkg::SP_FULL) begin
            res.trap = cpu8eu_pkg::TRAP_OVERFLOW;
          end else begin
            stk_wr.w0_en   = 1'b1;
            stk_wr.w0_addr = regs.sp;
            stk_wr.w0_data = read_reg(regs, item.src_reg);
            rn.sp          = regs.sp - 8'd1;
          end
        end
        cpu8eu_pkg::FN_PULL: begin
          if (regs.sp == cpu8eu_pkg::SP_EMPTY) begin
            res.trap = cpu8eu_pkg::TRAP_UNDERFLOW;
            v        = 8'h00;
          end else begin
            rn.sp = regs.sp + 8'd1;
            v     = stk_byte0;
          end
          rn = write_reg(rn, item.dst_reg, v);
        end
        cpu8eu_pkg::FN_JMP: res.new_pc = item.eff_address;
        cpu8eu_pkg::FN_JSR: begin
          ret = item.next_pc - 16'd1;
          if (regs.sp == cpu8eu_pkg::SP_FULL) begin
            res.trap = cpu8eu_pkg::TRAP_OVERFLOW;
          end else begin
            stk_wr.w0_en   = 1'b1;
            stk_wr.w0_addr = regs.sp;
            stk_wr.w0_data = ret[15:8];
            if (regs.sp == 8'd1) begin
              res.trap = cpu8eu_pkg::TRAP_OVERFLOW;
              rn.sp    = cpu8eu_pkg::SP_FULL;
            end else begin
              stk_wr.w1_en   = 1'b1;
              stk_wr.w1_addr = regs.sp - 8'd1;
              stk_wr.w1_data = ret[7:0];
              rn.sp          = regs.sp - 8'd2;
            end
          end
          res.new_pc = item.eff_address;
        end
        cpu8eu_pkg::FN_RTS: begin
          if (regs.sp == cpu8eu_pkg::SP_EMPTY) begin
            res.trap = cpu8eu_pkg::TRAP_UNDERFLOW;
          end else if (regs.sp == cpu8eu_pkg::SP_EMPTY - 8'd1) begin
            lo       = stk_byte0;
            rn.sp    = cpu8eu_pkg::SP_EMPTY;
            res.trap = cpu8eu_pkg::TRAP_UNDERFLOW;
          end else begin
            lo    = stk_byte0;
            hi    = stk_byte1;
            rn.sp = regs.sp + 8'd2;
          end
          res.new_pc = {hi, lo} + 16'd1;
        end
        cpu8eu_pkg::FN_BRANCH: begin
          if (regs.p[item.flag_bit] == item.br_on_set) begin
            res.new_pc = item.next_pc + {{8{m[7]}}, m};
          end
        end
        cpu8eu_pkg::FN_CLRFLAG: rn.p[item.flag_bit] = 1'b0;
        cpu8eu_pkg::FN_SETFLAG: rn.p[item.flag_bit] = 1'b1;
        cpu8eu_pkg::FN_TRANSFER:
          rn = write_reg(regs, item.dst_reg, read_reg(regs, item.src_reg));
        default: rn = regs;
      endcase
    end

    regs_next = rn;
  end

endmodule
